// ----- hdl/mu8_pkg.sv -----
// shared types and constants for the modified utf-8 to utf-8 decoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mu8_pkg;

   localparam int MU8_Q_DEPTH = 4;
   localparam int MU8_Q_PTR_W = $clog2(MU8_Q_DEPTH);
   localparam int MU8_Q_CNT_W = $clog2(MU8_Q_DEPTH + 1);

   localparam int MU8_CP_W = 21;
   localparam int MU8_UNIT_W = 16;

   localparam logic [MU8_CP_W-1:0] MU8_SUPP_BASE = 21'h10000;
   localparam logic [5:0] MU8_HIGH_SURR_TAG = 6'b110110;
   localparam logic [5:0] MU8_LOW_SURR_TAG = 6'b110111;

   // output byte counts of one command
   localparam logic [2:0] MU8_NB_NONE = 3'd0;
   localparam logic [2:0] MU8_NB_ONE = 3'd1;
   localparam logic [2:0] MU8_NB_TWO = 3'd2;
   localparam logic [2:0] MU8_NB_THREE = 3'd3;
   localparam logic [2:0] MU8_NB_FOUR = 3'd4;

   typedef struct packed {
      logic [MU8_CP_W-1:0] code_point;
      logic [2:0]          n_bytes;
      logic                str_end;
      logic                err;
   } mu8_cmd_type;

endpackage

`default_nettype wire

// ----- hdl/mu8_req_if.sv -----
// request channel: one modified utf-8 byte and its end-of-string flag
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface mu8_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       last_byte;

   modport source (output valid, output in_byte, output last_byte, input ready);
   modport sink (input valid, input in_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ----- hdl/mu8_rsp_if.sv -----
// response channel: one standard utf-8 byte with string status
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface mu8_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       string_end;
   logic       error;

   modport source (output valid, output out_byte, output byte_valid,
                   output string_end, output error, input ready);
   modport sink (input valid, input out_byte, input byte_valid,
                 input string_end, input error, output ready);
endinterface

`default_nettype wire

// ----- hdl/modified_utf8_to_utf8_decoder.sv -----
// Converts a Java modified UTF-8 byte stream to standard UTF-8. One request
// byte is taken per cycle while the four-entry command queue has room; the
// front end decodes it and queues at most one command per request. The back
// end sends one response byte per cycle while rsp_bus is ready, from the
// command at the queue head; a unit of n output bytes holds it until all n
// are taken (a surrogate pair gives four bytes from six requests, so output
// keeps pace). Commands pass via the queue and a current-command register.
// When a string fails to decode, no further bytes are sent for it and its
// last request yields one status-only response with string_end and error set.
// depends on mu8_pkg, mu8_req_if, mu8_rsp_if, mu8_front, mu8_queue, mu8_back
`timescale 1ns / 1ps
`default_nettype none

module modified_utf8_to_utf8_decoder
   import mu8_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   mu8_req_if.sink   req_bus,
   mu8_rsp_if.source rsp_bus
);

   mu8_cmd_type push_cmd;
   mu8_cmd_type head_cmd;
   logic        push;
   logic        pop;
   logic        full;
   logic        empty;

   mu8_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .q_full   (full),
      .cmd      (push_cmd),
      .cmd_push (push)
   );

   mu8_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_cmd),
      .pop       (pop),
      .head      (head_cmd),
      .full      (full),
      .empty     (empty)
   );

   mu8_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (head_cmd),
      .q_empty (empty),
      .q_pop   (pop),
      .rsp_bus (rsp_bus)
   );

endmodule

`default_nettype wire

// ----- hdl/mu8_front.sv -----
// front end: decodes modified utf-8 bytes into code point commands
// depends on mu8_pkg and mu8_req_if
`timescale 1ns / 1ps
`default_nettype none

module mu8_front
   import mu8_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   mu8_req_if.sink     req_bus,
   input  wire logic   q_full,
   output mu8_cmd_type cmd,
   output logic        cmd_push
);

   logic [1:0]            units_needed_ff, units_needed_in;
   logic [MU8_UNIT_W-1:0] unit_partial_ff, unit_partial_in;
   logic                  high_pending_ff, high_pending_in;
   logic [9:0]            high_bits_ff, high_bits_in;
   logic                  failed_ff, failed_in;

   logic                  accept;
   logic                  unit_ok;
   logic [MU8_UNIT_W-1:0] unit;
   logic [MU8_UNIT_W-1:0] merged;
   logic                  emit;
   logic [MU8_CP_W-1:0]   cp;
   logic [2:0]            nb;
   logic [7:0]            b;

   assign req_bus.ready = !q_full;
   assign accept = req_bus.valid && req_bus.ready;
   assign b = req_bus.in_byte;
   assign merged = {unit_partial_ff[9:0], b[5:0]};

   always_comb begin
      units_needed_in = units_needed_ff;
      unit_partial_in = unit_partial_ff;
      high_pending_in = high_pending_ff;
      high_bits_in = high_bits_ff;
      failed_in = failed_ff;
      unit_ok = 1'b0;
      unit = '0;
      emit = 1'b0;
      cp = '0;

      if (!failed_ff) begin
         if (units_needed_ff == 2'd0) begin
            if (!b[7]) begin
               unit_ok = 1'b1;
               unit = {8'h00, b};
            end else if (b[7:5] == 3'b110) begin
               unit_partial_in = {11'h000, b[4:0]};
               units_needed_in = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
               unit_partial_in = {12'h000, b[3:0]};
               units_needed_in = 2'd2;
            end else begin
               failed_in = 1'b1;
            end
         end else if (b[7:6] != 2'b10) begin
            failed_in = 1'b1;
         end else begin
            units_needed_in = units_needed_ff - 2'd1;
            if (units_needed_ff == 2'd1) begin
               unit_ok = 1'b1;
               unit = merged;
               unit_partial_in = '0;
            end else begin
               unit_partial_in = merged;
            end
         end
      end

      // surrogate pairing
      if (unit_ok) begin
         if (high_pending_ff) begin
            if (unit[15:10] == MU8_LOW_SURR_TAG) begin
               cp = MU8_SUPP_BASE + {1'b0, high_bits_ff, unit[9:0]};
               high_pending_in = 1'b0;
               high_bits_in = '0;
               emit = 1'b1;
            end else begin
               failed_in = 1'b1;
            end
         end else if (unit[15:10] == MU8_HIGH_SURR_TAG) begin
            high_pending_in = 1'b1;
            high_bits_in = unit[9:0];
         end else begin
            cp = {5'b00000, unit};
            emit = 1'b1;
         end
      end

      priority if (cp <= 21'h7F) nb = MU8_NB_ONE;
      else if (cp <= 21'h7FF) nb = MU8_NB_TWO;
      else if (cp <= 21'hFFFF) nb = MU8_NB_THREE;
      else nb = MU8_NB_FOUR;

      cmd.code_point = cp;
      cmd.n_bytes = emit ? nb : MU8_NB_NONE;
      cmd.str_end = 1'b0;
      cmd.err = 1'b0;
      cmd_push = accept && emit;

      if (req_bus.last_byte) begin
         // truncated unit or dangling high surrogate
         if (!failed_in && (units_needed_in != 2'd0 || high_pending_in)) begin
            failed_in = 1'b1;
         end
         cmd.str_end = 1'b1;
         cmd.err = failed_in;
         if (failed_in) begin
            cmd.n_bytes = MU8_NB_NONE;
         end
         cmd_push = accept;
         units_needed_in = '0;
         unit_partial_in = '0;
         high_pending_in = 1'b0;
         high_bits_in = '0;
         failed_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         units_needed_ff <= '0;
         unit_partial_ff <= '0;
         high_pending_ff <= 1'b0;
         high_bits_ff <= '0;
         failed_ff <= 1'b0;
      end else if (accept) begin
         units_needed_ff <= units_needed_in;
         unit_partial_ff <= unit_partial_in;
         high_pending_ff <= high_pending_in;
         high_bits_ff <= high_bits_in;
         failed_ff <= failed_in;
      end
   end

   a_no_push_when_failed: assert property (@(posedge clock) disable iff (reset)
      (cmd_push && failed_ff) |-> (cmd.str_end && cmd.err))
      else $error("front pushed data after failure");

   a_push_only_on_accept: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> accept)
      else $error("front pushed without accepted request");

   a_end_clears_state: assert property (@(posedge clock) disable iff (reset)
      (accept && req_bus.last_byte) |=> (!failed_ff && !high_pending_ff
                                         && units_needed_ff == 2'd0))
      else $error("string state not cleared after last byte");

endmodule

`default_nettype wire

// ----- hdl/mu8_queue.sv -----
// short command queue between the decoding front end and the byte serializer
// depends on mu8_pkg
`timescale 1ns / 1ps
`default_nettype none

module mu8_queue
   import mu8_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire mu8_cmd_type  push_data,
   input  wire logic         pop,
   output mu8_cmd_type       head,
   output logic              full,
   output logic              empty
);

   mu8_cmd_type            store_ff [MU8_Q_DEPTH];
   logic [MU8_Q_PTR_W-1:0] wr_ptr_ff;
   logic [MU8_Q_PTR_W-1:0] rd_ptr_ff;
   logic [MU8_Q_CNT_W-1:0] count_ff;

   assign full = (count_ff == MU8_Q_CNT_W'(MU8_Q_DEPTH));
   assign empty = (count_ff == '0);
   assign head = store_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + MU8_Q_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + MU8_Q_PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + MU8_Q_CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - MU8_Q_CNT_W'(1);
         end
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("queue underflow");

   a_pointer_count: assert property (@(posedge clock) disable iff (reset)
      empty |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ----- hdl/mu8_back.sv -----
// back end: serializes code point commands into standard utf-8 bytes
// depends on mu8_pkg and mu8_rsp_if
`timescale 1ns / 1ps
`default_nettype none

module mu8_back
   import mu8_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire mu8_cmd_type  head,
   input  wire logic         q_empty,
   output logic              q_pop,
   mu8_rsp_if.source         rsp_bus
);

   mu8_cmd_type cur_ff;
   logic        cur_valid_ff;
   logic [1:0]  idx_ff;

   logic        take;
   logic        is_last;
   logic [2:0]  last_idx;
   logic [MU8_CP_W-1:0] cp;
   logic [7:0]  obyte;

   assign cp = cur_ff.code_point;
   assign take = rsp_bus.valid && rsp_bus.ready;
   assign last_idx = (cur_ff.n_bytes == MU8_NB_NONE) ? 3'd0 : cur_ff.n_bytes - 3'd1;
   assign is_last = (idx_ff == last_idx[1:0]);
   assign q_pop = !q_empty && (!cur_valid_ff || (take && is_last));

   always_comb begin
      obyte = 8'h00;
      unique case (cur_ff.n_bytes)
         MU8_NB_NONE: obyte = 8'h00;
         MU8_NB_ONE: obyte = cp[7:0];
         MU8_NB_TWO: begin
            unique case (idx_ff)
               2'd0: obyte = {3'b110, cp[10:6]};
               default: obyte = {2'b10, cp[5:0]};
            endcase
         end
         MU8_NB_THREE: begin
            unique case (idx_ff)
               2'd0: obyte = {4'b1110, cp[15:12]};
               2'd1: obyte = {2'b10, cp[11:6]};
               default: obyte = {2'b10, cp[5:0]};
            endcase
         end
         MU8_NB_FOUR: begin
            unique case (idx_ff)
               2'd0: obyte = {5'b11110, cp[20:18]};
               2'd1: obyte = {2'b10, cp[17:12]};
               2'd2: obyte = {2'b10, cp[11:6]};
               default: obyte = {2'b10, cp[5:0]};
            endcase
         end
         default: obyte = 8'h00;
      endcase
   end

   assign rsp_bus.valid = cur_valid_ff;
   assign rsp_bus.out_byte = obyte;
   assign rsp_bus.byte_valid = (cur_ff.n_bytes != MU8_NB_NONE);
   assign rsp_bus.string_end = cur_ff.str_end && is_last;
   assign rsp_bus.error = cur_ff.err && is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff <= '0;
      end else if (q_pop) begin
         cur_valid_ff <= 1'b1;
         idx_ff <= '0;
      end else if (take) begin
         if (is_last) begin
            cur_valid_ff <= 1'b0;
            idx_ff <= '0;
         end else begin
            idx_ff <= idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= head;
      end
   end

   a_status_only_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.byte_valid) |-> rsp_bus.string_end)
      else $error("status-only response without string end");

   a_error_on_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.error) |-> (rsp_bus.string_end && !rsp_bus.byte_valid))
      else $error("error flagged on a data byte");

   a_index_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.ready) |=> (cur_valid_ff && $stable(idx_ff)))
      else $error("byte index moved while stalled");

endmodule

`default_nettype wire
